[src/satt_pkg.sv]
package satt_pkg;

    // Command codes
    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Bound kinds
    localparam logic [1:0] BND_EXACT = 2'd3;

    // Register map (word index on the APB port)
    localparam logic REG_GENERATION   = 1'b0;
    localparam logic REG_CLUSTER_BITS = 1'b1;

    localparam int TAG_W = 32;

    // One stored way: 106 bits
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [15:0]      score;
        logic [1:0]       bound;
        logic [15:0]      depth;
        logic [15:0]      move;
        logic [15:0]      eval;
        logic [7:0]       gen;
    } entry_t;

    // Input beat
    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        position_key;
        logic signed [15:0] score;
        logic [1:0]         bound_kind;
        logic signed [15:0] search_depth;
        logic [15:0]        best_move;
        logic signed [15:0] static_eval;
    } item_t;

    // Output beat
    typedef struct packed {
        logic               hit;
        logic [1:0]         way_index;
        logic signed [15:0] found_score;
        logic [1:0]         found_bound;
        logic signed [15:0] found_depth;
        logic [15:0]        found_move;
        logic signed [15:0] found_eval;
        logic [7:0]         found_generation;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch item, read its cluster
        logic fire;      // evaluate, write back, load result
        logic sweep_wr;  // write an empty row at the sweep address
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_is_clear;
        logic out_free;
    } dp_status_t;

    function automatic result_t make_result(logic hit, logic [1:0] way, entry_t e);
        result_t r;
        r.hit              = hit;
        r.way_index        = way;
        r.found_score      = e.score;
        r.found_bound      = e.bound;
        r.found_depth      = e.depth;
        r.found_move       = e.move;
        r.found_eval       = e.eval;
        r.found_generation = e.gen;
        return r;
    endfunction

endpackage

[src/satt_ctrl.sv]
module satt_ctrl #(
    parameter int MAX_CLUSTER_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  satt_pkg::dp_status_t          status,
    output satt_pkg::ctrl_cmd_t           cmd,
    output logic [MAX_CLUSTER_BITS-1:0]   sweep_addr
);
    import satt_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_EVAL,
        ST_CLR_SWEEP
    } state_t;

    state_t                        state_reg, state_next;
    logic [MAX_CLUSTER_BITS-1:0]   cnt_reg, cnt_next;
    logic                          sweep_last;
    logic                          accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign sweep_last = (cnt_reg == {MAX_CLUSTER_BITS{1'b1}});
    assign sweep_addr = cnt_reg;

    // Commands to the datapath
    always_comb
    begin
        cmd.load     = accept;
        cmd.fire     = (state_reg == ST_EVAL) && status.out_free;
        cmd.sweep_wr = (state_reg == ST_INIT_SWEEP) || (state_reg == ST_CLR_SWEEP);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_INIT_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = status.item_is_clear ? ST_CLR_SWEEP : ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            ST_CLR_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (sweep_last)
                    state_next = ST_EVAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_SWEEP;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[src/satt_datapath.sv]
module satt_datapath #(
    parameter int MAX_CLUSTER_BITS = 12,
    parameter int WAYS             = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  satt_pkg::item_t               item,
    input  logic [7:0]                    cur_gen,
    input  logic [3:0]                    cluster_bits,
    input  satt_pkg::ctrl_cmd_t           cmd,
    input  logic [MAX_CLUSTER_BITS-1:0]   sweep_addr,
    output satt_pkg::dp_status_t          status,
    output logic                          result_valid,
    input  logic                          result_ready,
    output satt_pkg::result_t             result
);
    import satt_pkg::*;

    localparam int DEPTH  = 1 << MAX_CLUSTER_BITS;
    localparam int WAY_BW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef entry_t [WAYS-1:0] row_t;

    row_t                          mem [DEPTH];
    row_t                          row_reg;
    item_t                         item_reg;
    logic [MAX_CLUSTER_BITS-1:0]   idx_reg;
    logic [MAX_CLUSTER_BITS-1:0]   idx_mask;
    logic [MAX_CLUSTER_BITS-1:0]   rd_idx;
    logic                          out_valid_reg;
    result_t                       out_reg, out_next;

    logic [TAG_W-1:0]   tag;
    logic               probe_hit, free_hit;
    logic [WAY_BW-1:0]  probe_way, free_way, vict, pick;
    entry_t             cur_e, new_e;
    logic               old_fresh, cand_kept;
    logic [15:0]        mv;
    row_t               new_row;

    // Cluster index: low key bits under the configured mask
    always_comb
    begin
        for (int i = 0; i < MAX_CLUSTER_BITS; i++)
            idx_mask[i] = (32'(i) < 32'(cluster_bits));
    end
    assign rd_idx = item.position_key[MAX_CLUSTER_BITS-1:0] & idx_mask;

    // Table memory: one cluster per row
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            row_reg <= mem[rd_idx];
        if (cmd.sweep_wr)
            mem[sweep_addr] <= '0;
        else if (cmd.fire && item_reg.command == CMD_STORE)
            mem[idx_reg] <= new_row;
    end

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            idx_reg  <= rd_idx;
        end
    end

    // Way search and replacement choice
    always_comb
    begin
        tag       = item_reg.position_key[63:32];
        probe_hit = 1'b0;
        probe_way = '0;
        free_hit  = 1'b0;
        free_way  = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (row_reg[i].tag == tag)
            begin
                probe_hit = 1'b1;
                probe_way = WAY_BW'(i);
            end
            if (row_reg[i].tag == '0 || row_reg[i].tag == tag)
            begin
                free_hit = 1'b1;
                free_way = WAY_BW'(i);
            end
        end

        // victim: stale beats fresh/exact, then shallower depth
        vict = '0;
        for (int i = 1; i < WAYS; i++)
        begin
            cur_e     = row_reg[vict];
            old_fresh = (cur_e.gen == cur_gen);
            cand_kept = (row_reg[i].gen == cur_gen) || (row_reg[i].bound == BND_EXACT);
            if ((old_fresh && !cand_kept) ||
                ((old_fresh == cand_kept) &&
                 ($signed(row_reg[i].depth) < $signed(cur_e.depth))))
                vict = WAY_BW'(i);
        end

        pick = free_hit ? free_way : vict;

        // keep the reused way's old move when no new one is given
        mv = item_reg.best_move;
        if (free_hit && mv == '0)
            mv = row_reg[free_way].move;

        new_e.tag   = tag;
        new_e.score = item_reg.score;
        new_e.bound = item_reg.bound_kind;
        new_e.depth = item_reg.search_depth;
        new_e.move  = mv;
        new_e.eval  = item_reg.static_eval;
        new_e.gen   = cur_gen;

        new_row       = row_reg;
        new_row[pick] = new_e;

        unique case (item_reg.command)
            CMD_PROBE:
            begin
                if (probe_hit)
                    out_next = make_result(1'b1, 2'(probe_way), row_reg[probe_way]);
                else
                    out_next = '0;
            end
            CMD_STORE:
            begin
                out_next = make_result(1'b1, 2'(pick), new_e);
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.fire)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
            out_reg <= out_next;
    end

    assign result_valid         = out_valid_reg;
    assign result               = out_reg;
    assign status.out_free      = !out_valid_reg || result_ready;
    assign status.item_is_clear = (item.command == CMD_CLEAR);

endmodule

[src/set_assoc_transposition_table_unit.sv]
// Probe and store: the beat and its cluster row are registered, then the result is
// registered once the output is free; no new beat is taken until then (one cluster
// read, then evaluate and write back). Clear: 2**MAX_CLUSTER_BITS row writes, one row
// per cycle, then the result. Reset: registers go to generation 0 and 12 cluster bits;
// the table is then swept empty, during which no input beat is taken.
module set_assoc_transposition_table_unit #(
    parameter int MAX_CLUSTER_BITS = 12,
    parameter int WAYS             = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  satt_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_ready,
    output satt_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import satt_pkg::*;

    logic [7:0]                  gen_reg;
    logic [3:0]                  cbits_reg;
    logic                        reg_sel;
    ctrl_cmd_t                   cmd;
    dp_status_t                  status;
    logic [MAX_CLUSTER_BITS-1:0] sweep_addr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg   <= 8'd0;
            cbits_reg <= 4'd12;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_GENERATION:   gen_reg   <= pwdata[7:0];
                REG_CLUSTER_BITS: cbits_reg <= pwdata[3:0];
                default:          ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (reg_sel)
            REG_GENERATION:   prdata = {24'd0, gen_reg};
            REG_CLUSTER_BITS: prdata = {28'd0, cbits_reg};
            default:          prdata = '0;
        endcase
    end

    satt_ctrl #(
        .MAX_CLUSTER_BITS (MAX_CLUSTER_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd),
        .sweep_addr (sweep_addr)
    );

    satt_datapath #(
        .MAX_CLUSTER_BITS (MAX_CLUSTER_BITS),
        .WAYS             (WAYS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cur_gen      (gen_reg),
        .cluster_bits (cbits_reg),
        .cmd          (cmd),
        .sweep_addr   (sweep_addr),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[tb/set_assoc_transposition_table_unit_tb.sv]
`timescale 1ns / 100ps

module set_assoc_transposition_table_unit_tb;
    import satt_pkg::*;

    localparam int MAX_CLUSTER_BITS = 12;
    localparam int WAYS             = 4;
    localparam int ROWS             = 1 << MAX_CLUSTER_BITS;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int IDLE_PCT         = 12;
    localparam int STALL_LIMIT      = 20000;
    localparam int HOLD_CYCLES      = 400;
    localparam int PHASES           = 10;
    localparam int PHASE_ITEMS      = 165;

    // Shadow copy of the table; predicts each answer when its request beat is taken
    class tt_shadow;
        entry_t     slots[ROWS*WAYS];
        logic [7:0] gen;
        logic [3:0] idx_bits;
        result_t    pending[$];
        int         errors;
        int         n_probe, n_hit, n_store, n_evict, n_clear;

        function new();
            foreach (slots[i]) slots[i] = '0;
            gen      = 8'd0;
            idx_bits = 4'd12;
            errors   = 0;
            n_probe  = 0;
            n_hit    = 0;
            n_store  = 0;
            n_evict  = 0;
            n_clear  = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] v);
            if (idx == REG_GENERATION)
                gen = v[7:0];
            else
                idx_bits = v[3:0];
        endfunction

        function int row_base(logic [63:0] key);
            int          bits;
            logic [63:0] mask;
            bits = (idx_bits > MAX_CLUSTER_BITS) ? MAX_CLUSTER_BITS : int'(idx_bits);
            mask = (64'd1 << bits) - 64'd1;
            return int'(key & mask) * WAYS;
        endfunction

        function result_t pack_answer(logic hit, logic [1:0] way, entry_t e);
            result_t r;
            r.hit              = hit;
            r.way_index        = way;
            r.found_score      = e.score;
            r.found_bound      = e.bound;
            r.found_depth      = e.depth;
            r.found_move       = e.move;
            r.found_eval       = e.eval;
            r.found_generation = e.gen;
            return r;
        endfunction

        function void take_request(item_t it);
            int          base;
            int          pick;
            int          sc;
            bit          placed;
            logic [31:0] tag;
            logic [15:0] mv;
            entry_t      t;
            entry_t      r;
            entry_t      w;
            result_t     res;
            res  = '0;
            tag  = it.position_key[63:32];
            base = row_base(it.position_key);
            case (it.command)
                CMD_PROBE:
                begin
                    n_probe++;
                    pick = -1;
                    // first way with a matching tag wins
                    for (int i = WAYS - 1; i >= 0; i--)
                        if (slots[base+i].tag == tag)
                            pick = i;
                    if (pick >= 0)
                    begin
                        n_hit++;
                        res = pack_answer(1'b1, 2'(pick), slots[base+pick]);
                    end
                end
                CMD_STORE:
                begin
                    n_store++;
                    mv     = it.best_move;
                    pick   = 0;
                    placed = 1'b0;
                    for (int i = 0; i < WAYS; i++)
                    begin
                        if (!placed)
                        begin
                            t = slots[base+i];
                            r = slots[base+pick];
                            if (t.tag == '0 || t.tag == tag)
                            begin
                                // empty or same position: reuse, keep old move if none given
                                if (mv == '0)
                                    mv = t.move;
                                pick   = i;
                                placed = 1'b1;
                            end
                            else
                            begin
                                // victim scoring: age, exact bound, shallower depth
                                sc = (r.gen == gen) ? 2 : 0;
                                if (t.gen == gen || t.bound == BND_EXACT)
                                    sc -= 2;
                                if ($signed(t.depth) < $signed(r.depth))
                                    sc += 1;
                                if (sc > 0)
                                    pick = i;
                            end
                        end
                    end
                    if (!placed)
                        n_evict++;
                    w.tag   = tag;
                    w.score = it.score;
                    w.bound = it.bound_kind;
                    w.depth = it.search_depth;
                    w.move  = mv;
                    w.eval  = it.static_eval;
                    w.gen   = gen;
                    slots[base+pick] = w;
                    res = pack_answer(1'b1, 2'(pick), w);
                end
                CMD_CLEAR:
                begin
                    n_clear++;
                    foreach (slots[i]) slots[i] = '0;
                end
                default:
                begin
                end
            endcase
            pending.push_back(res);
        endfunction

        function void same(string what, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void match_answer(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected answer beat %0h", $time, got);
                return;
            end
            want = pending.pop_front();
            same("hit", 16'(want.hit), 16'(got.hit));
            same("way_index", 16'(want.way_index), 16'(got.way_index));
            same("found_score", want.found_score, got.found_score);
            same("found_bound", 16'(want.found_bound), 16'(got.found_bound));
            same("found_depth", want.found_depth, got.found_depth);
            same("found_move", want.found_move, got.found_move);
            same("found_eval", want.found_eval, got.found_eval);
            same("found_generation", 16'(want.found_generation), 16'(got.found_generation));
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    tt_shadow    shadow       = new();
    bit          steady       = 1'b0;
    bit          hold_req     = 1'b0;
    int          quiet        = 0;
    logic [31:0] tag_pool[10];
    logic [11:0] row_pool[8];

    set_assoc_transposition_table_unit #(
        .MAX_CLUSTER_BITS (MAX_CLUSTER_BITS),
        .WAYS             (WAYS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Beat monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            shadow.take_request(item);
        if (rst_n && result_valid && result_ready)
            shadow.match_answer(result);
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("set_assoc_transposition_table_unit_tb: errors");
            $finish;
        end
    end

    // Answer side: random back-pressure, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one request beat; returns at the edge where it is taken
    task automatic send_item(input item_t it);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    // Quiesce: no request offered, all answers back
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow.set_reg(idx, v);
    endtask

    function automatic item_t mk(logic [1:0] cmd, logic [63:0] key, logic [15:0] sc,
                                 logic [1:0] bk, logic [15:0] dp, logic [15:0] mv,
                                 logic [15:0] ev);
        item_t it;
        it.command      = cmd;
        it.position_key = key;
        it.score        = sc;
        it.bound_kind   = bk;
        it.search_depth = dp;
        it.best_move    = mv;
        it.static_eval  = ev;
        return it;
    endfunction

    // Keys mostly from small tag and row sets so clusters fill and evict
    function automatic logic [63:0] pick_key();
        logic [31:0] hi;
        logic [31:0] lo;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 5)
            hi = '0;
        else if (sel < 15)
            hi = $urandom;
        else
            hi = tag_pool[$urandom_range(9)];
        lo = $urandom;
        if ($urandom_range(99) < 80)
            lo[11:0] = row_pool[$urandom_range(7)];
        return {hi, lo};
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    c;
        c = $urandom_range(299);
        if (c < 2)
            it.command = CMD_CLEAR;
        else if (c < 10)
            it.command = CMD_NONE;
        else if (c < 150)
            it.command = CMD_PROBE;
        else
            it.command = CMD_STORE;
        it.position_key = pick_key();
        it.score        = 16'($urandom);
        it.bound_kind   = 2'($urandom);
        // narrow depths give ties in victim scoring
        if ($urandom_range(1) == 0)
            it.search_depth = 16'($urandom);
        else
            it.search_depth = 16'($urandom_range(16)) - 16'd8;
        it.best_move    = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        it.static_eval  = 16'($urandom);
        return it;
    endfunction

    initial
    begin
        logic [7:0]  gen_list[PHASES];
        logic [3:0]  bits_list[PHASES];
        logic [63:0] k1;
        gen_list  = '{8'd1, 8'd255, 8'd0, 8'd77, 8'd200, 8'd255, 8'd3, 8'd128, 8'd9, 8'd64};
        bits_list = '{4'd2, 4'd0, 4'd12, 4'd1, 4'd15, 4'd3, 4'd13, 4'd2, 4'd0, 4'd4};
        k1 = 64'hA5A5_0001_0000_0005;
        tag_pool[0] = 32'hFFFF_FFFF;
        tag_pool[1] = 32'h0000_0001;
        for (int i = 2; i < 10; i++)
            tag_pool[i] = $urandom;
        row_pool[0] = 12'h000;
        row_pool[1] = 12'hFFF;
        for (int i = 2; i < 8; i++)
            row_pool[i] = 12'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero tag, misses, extremes, move retention, eviction, clear
        send_item(mk(CMD_PROBE, 64'd0, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_PROBE, '1, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_STORE, k1, 16'h8000, BND_EXACT, 16'h7FFF, 16'hFFFF, 16'h7FFF));
        send_item(mk(CMD_PROBE, k1, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_STORE, k1, 16'h7FFF, 2'd0, 16'h8000, 16'd0, 16'h8000));
        send_item(mk(CMD_PROBE, k1, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_STORE, 64'h0000_0002_0000_0005, 16'd1, 2'd1, 16'd10, 16'd7, 16'd2));
        send_item(mk(CMD_STORE, 64'h0000_0003_0000_0005, 16'd3, 2'd2, -16'sd5, 16'd0, 16'd4));
        send_item(mk(CMD_STORE, 64'h0000_0004_0000_0005, 16'd5, 2'd3, 16'd3, 16'd9, 16'd6));
        send_item(mk(CMD_STORE, 64'h0000_0005_0000_0005, 16'd8, 2'd2, 16'd1, 16'd1, 16'd1));
        send_item(mk(CMD_PROBE, 64'h0000_0000_0000_0005, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_NONE, '1, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(mk(CMD_STORE, '1, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(mk(CMD_PROBE, '1, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_CLEAR, 64'd0, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_PROBE, k1, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk(CMD_PROBE, 64'd0, 16'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        settle();

        // Random phases, each under its own generation and index width
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_GENERATION, {24'd0, gen_list[p]});
            write_reg(REG_CLUSTER_BITS, {28'd0, bits_list[p]});
            steady = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 5 && k == 20)
                    hold_req = 1'b1;
                send_item(random_item());
            end
            settle();
        end
        steady = 1'b0;
        repeat (10) @(posedge clk);

        $display("covered %0d probes (%0d hits), %0d stores (%0d evictions), %0d clears",
                 shadow.n_probe, shadow.n_hit, shadow.n_store, shadow.n_evict, shadow.n_clear);
        $display("over %0d generation and index-width settings, index widths 0 to 15",
                 PHASES + 1);
        if (shadow.errors == 0)
            $display("set_assoc_transposition_table_unit_tb: clean");
        else
            $display("set_assoc_transposition_table_unit_tb: errors");
        $finish;
    end

endmodule

[files.f]
src/satt_pkg.sv
src/satt_ctrl.sv
src/satt_datapath.sv
src/set_assoc_transposition_table_unit.sv
tb/set_assoc_transposition_table_unit_tb.sv
